@@ design/pcd_pkg.sv @@
// Shared widths, register indexes and constants for the clamped PID drive block.
package pcd_pkg;

    // Field and register widths.
    localparam int GAIN_W  = 16;
    localparam int SAMP_W  = 16;
    localparam int DRIVE_W = 7;
    localparam int IDX_W   = 2;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 2'd2;

    // Reset values of the gains.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd1000;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd0;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd0;

    // Internal widths, all in units of 1/100000 where they hold a drive quantity.
    localparam int ERR_W   = 17;  // setpoint - measured
    localparam int DELTA_W = 18;  // error - previous error
    localparam int PROD_W  = 34;  // 17-bit signed gain times 17-bit error
    localparam int DPROD_W = 35;  // 17-bit signed gain times 18-bit delta
    localparam int P10_W   = 37;  // proportional product times 10
    localparam int D100_W  = 41;  // derivative product times 100
    localparam int INTEG_W = 48;
    localparam int INCR_W  = 50;
    localparam int SUM_W   = 51;
    localparam int OUT_W   = 24;

    localparam logic [OUT_W-1:0] OUT_ACC_MAX = 24'd10000000;

    // Division by 100000 as a multiply by ceil(2^40 / 100000); exact for 0..10000000.
    localparam int             RECIP_SHIFT = 40;
    localparam logic [23:0]    RECIP_MULT  = 24'd10995117;
    localparam int             RPROD_W     = 48;

    typedef logic signed [ERR_W-1:0]   t_err;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic signed [INTEG_W-1:0] t_integ;
    typedef logic signed [INCR_W-1:0]  t_incr;

endpackage

@@ design/pid_clamped_drive.sv @@
// Incremental PID controller with saturating integral and a 0..100 clamped drive output.
//
// Each input beat carries a setpoint and a measurement; each produces exactly one output
// beat with the drive value 0..100, in the order the inputs arrived. The error is
// setpoint - measured. The integral term adds integ_gain * error and saturates at signed
// 48 bits. The increment proportional*10 + integral + derivative*100 (all in 1/100000 drive
// units) is added to an output accumulator that is clamped to 0..100 drive units, and the
// drive is the accumulator's whole part. The block is a six-stage pipeline: it takes one
// beat every clock cycle when no stage is held up by the output side, and raises o_valid
// with its result when the beat reaches the output register in stage six. The rate is
// set by the update loops on the integral register (stage three) and the output
// accumulator (stage five). Back-pressure on the output stalls only as many stages as are
// full, so input beats keep flowing into empty stages while a finished result waits. The
// gains are written through a simple write port (index 0 proportional, 1 integral, 2
// derivative; other indexes are ignored) and should only be changed while the pipeline is
// empty.
module pid_clamped_drive (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pcd_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [pcd_pkg::GAIN_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pcd_pkg::SAMP_W-1:0]   i_setpoint,
    input  logic [pcd_pkg::SAMP_W-1:0]   i_measured,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pcd_pkg::DRIVE_W-1:0]  o_drive
);
    import pcd_pkg::*;

    // Gain registers.
    logic [GAIN_W-1:0] r_prop_gain;
    logic [GAIN_W-1:0] r_integ_gain;
    logic [GAIN_W-1:0] r_deriv_gain;

    // Stage valid bits; stage 6 is the output register.
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic take1, take2, take3, take4, take5, take6;

    // Controller state.
    t_err             r_prev_err;
    t_integ           r_integ;
    logic [OUT_W-1:0] r_out_acc;

    // Pipeline payload.
    t_err                       r_err;
    t_delta                     r_delta;
    logic signed [PROD_W-1:0]   r_pprod;
    logic signed [PROD_W-1:0]   r_iprod;
    logic signed [DPROD_W-1:0]  r_dprod;
    logic signed [P10_W-1:0]    r_p10;
    logic signed [D100_W-1:0]   r_d100;
    t_incr                      r_incr;
    logic [DRIVE_W-1:0]         r_drive;

    // Next-value logic.
    t_err                       n_err;
    t_delta                     n_delta;
    logic signed [PROD_W-1:0]   n_pprod;
    logic signed [PROD_W-1:0]   n_iprod;
    logic signed [DPROD_W-1:0]  n_dprod;
    logic signed [P10_W-1:0]    p_ext;
    logic signed [D100_W-1:0]   d_ext;
    logic signed [P10_W-1:0]    n_p10;
    logic signed [D100_W-1:0]   n_d100;
    logic signed [INTEG_W:0]    integ_sum;
    t_integ                     n_integ;
    t_incr                      n_incr;
    logic signed [SUM_W-1:0]    out_sum;
    logic [OUT_W-1:0]           n_out_acc;
    logic [RPROD_W-1:0]         recip_prod;
    logic [DRIVE_W-1:0]         n_drive;

    // A stage can take a beat when it is empty or its own beat moves on this cycle.
    assign take6 = !r_v6 || i_ready;
    assign take5 = !r_v5 || take6;
    assign take4 = !r_v4 || take5;
    assign take3 = !r_v3 || take4;
    assign take2 = !r_v2 || take3;
    assign take1 = !r_v1 || take2;

    assign o_ready = take1;
    assign o_valid = r_v6;
    assign o_drive = r_drive;

    always_comb begin
        // Stage 1: error and its change since the previous sample.
        n_err   = t_err'($signed({1'b0, i_setpoint}) - $signed({1'b0, i_measured}));
        n_delta = t_delta'(n_err) - t_delta'(r_prev_err);

        // Stage 2: raw gain products.
        n_pprod = $signed({1'b0, r_prop_gain}) * r_err;
        n_iprod = $signed({1'b0, r_integ_gain}) * r_err;
        n_dprod = $signed({1'b0, r_deriv_gain}) * r_delta;

        // Stage 3: constant scaling by shift and add, and the saturating integral.
        p_ext  = P10_W'(r_pprod);
        d_ext  = D100_W'(r_dprod);
        n_p10  = (p_ext <<< 3) + (p_ext <<< 1);
        n_d100 = (d_ext <<< 6) + (d_ext <<< 5) + (d_ext <<< 2);

        integ_sum = (INTEG_W+1)'(r_integ) + (INTEG_W+1)'(r_iprod);
        // Overflow shows as the two top bits of the sum disagreeing.
        if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
            n_integ = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                         : {1'b0, {(INTEG_W-1){1'b1}}};
        end else begin
            n_integ = integ_sum[INTEG_W-1:0];
        end

        // Stage 4: the increment; r_integ already holds this beat's integral.
        n_incr = INCR_W'(r_p10) + INCR_W'(r_integ) + INCR_W'(r_d100);

        // Stage 5: accumulate and clamp to 0..100 drive units.
        out_sum = $signed({{(SUM_W-OUT_W){1'b0}}, r_out_acc}) + SUM_W'(r_incr);
        if (out_sum < 0) begin
            n_out_acc = '0;
        end else if (out_sum > $signed({{(SUM_W-OUT_W){1'b0}}, OUT_ACC_MAX})) begin
            n_out_acc = OUT_ACC_MAX;
        end else begin
            n_out_acc = out_sum[OUT_W-1:0];
        end

        // Stage 6: whole drive units by reciprocal multiply.
        recip_prod = {{(RPROD_W-OUT_W){1'b0}}, r_out_acc} * RPROD_W'(RECIP_MULT);
        n_drive    = recip_prod[RECIP_SHIFT+DRIVE_W-1:RECIP_SHIFT];
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= PROP_GAIN_RST;
            r_integ_gain <= INTEG_GAIN_RST;
            r_deriv_gain <= DERIV_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_PROP_GAIN:  r_prop_gain  <= i_cfg_data;
                REG_INTEG_GAIN: r_integ_gain <= i_cfg_data;
                REG_DERIV_GAIN: r_deriv_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Valid bits and controller state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_v4       <= 1'b0;
            r_v5       <= 1'b0;
            r_v6       <= 1'b0;
            r_prev_err <= '0;
            r_integ    <= '0;
            r_out_acc  <= '0;
        end else begin
            if (take1) r_v1 <= i_valid;
            if (take2) r_v2 <= r_v1;
            if (take3) r_v3 <= r_v2;
            if (take4) r_v4 <= r_v3;
            if (take5) r_v5 <= r_v4;
            if (take6) r_v6 <= r_v5;
            if (i_valid && take1) r_prev_err <= n_err;
            if (r_v2 && take3)    r_integ    <= n_integ;
            if (r_v4 && take5)    r_out_acc  <= n_out_acc;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_valid && take1) begin
            r_err   <= n_err;
            r_delta <= n_delta;
        end
        if (r_v1 && take2) begin
            r_pprod <= n_pprod;
            r_iprod <= n_iprod;
            r_dprod <= n_dprod;
        end
        if (r_v2 && take3) begin
            r_p10  <= n_p10;
            r_d100 <= n_d100;
        end
        if (r_v3 && take4) begin
            r_incr <= n_incr;
        end
        if (r_v5 && take6) begin
            r_drive <= n_drive;
        end
    end

endmodule

@@ tb/pid_clamped_drive_test.sv @@
// Self-checking testbench for the clamped PID drive block.
module pid_clamped_drive_test;
    import pcd_pkg::*;

    // The two-bit index field can address one register that does not exist.
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    // Scales of the controller arithmetic, all in units of 1/100000 drive.
    localparam longint UNITS_PER_DRIVE = 100000;
    localparam longint OUT_TOP         = 10000000;
    localparam longint OUT_MID         = 5000000;
    localparam longint PROP_SCALE      = 10;
    localparam longint DERIV_SCALE     = 100;
    localparam longint INTEG_HI        = (longint'(1) <<< 47) - 1;
    localparam longint INTEG_LO        = -(longint'(1) <<< 47);

    // Settle time after the last drive beat; the pipeline is six stages deep.
    localparam int PIPE_SLACK = 8;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [IDX_W-1:0]     i_cfg_idx;
    logic [GAIN_W-1:0]    i_cfg_data;
    logic                 i_valid;
    logic                 o_ready;
    logic [SAMP_W-1:0]    i_setpoint;
    logic [SAMP_W-1:0]    i_measured;
    logic                 o_valid;
    logic                 i_ready;
    logic [DRIVE_W-1:0]   o_drive;

    // Gains and controller state as the block should hold them.
    logic [GAIN_W-1:0]    kp_word;
    logic [GAIN_W-1:0]    ki_word;
    logic [GAIN_W-1:0]    kd_word;
    t_integ               integ_level;
    t_err                 last_err;
    logic [OUT_W-1:0]     out_level;

    // Drive values of accepted samples whose result beat has not come back yet.
    logic [DRIVE_W-1:0]   pending_drive_q[$];

    int bad_beats;
    int send_idle_pct;
    int recv_idle_pct;

    pid_clamped_drive uut (.*);

    always #2 i_clk = ~i_clk;

    // Runs one control sample through the controller state and returns its drive.
    // The integral saturates before it enters the increment, and the output
    // accumulator is clamped to the 0..100 drive range after the increment is added.
    function automatic logic [DRIVE_W-1:0] advance_controller(input logic [SAMP_W-1:0] sp,
                                                              input logic [SAMP_W-1:0] ms);
        longint err;
        longint slope;
        longint integ;
        longint incr;
        longint acc;
        err   = longint'(sp) - longint'(ms);
        slope = err - longint'(last_err);
        integ = longint'(integ_level) + longint'(ki_word) * err;
        if (integ > INTEG_HI) begin
            integ = INTEG_HI;
        end else if (integ < INTEG_LO) begin
            integ = INTEG_LO;
        end
        incr = longint'(kp_word) * err * PROP_SCALE + integ
             + longint'(kd_word) * slope * DERIV_SCALE;
        acc = longint'(out_level) + incr;
        if (acc > OUT_TOP) begin
            acc = OUT_TOP;
        end else if (acc < 0) begin
            acc = 0;
        end
        integ_level = integ[INTEG_W-1:0];
        last_err    = err[ERR_W-1:0];
        out_level   = acc[OUT_W-1:0];
        return DRIVE_W'(acc / UNITS_PER_DRIVE);
    endfunction

    function automatic void note_failure(input string msg);
        bad_beats++;
        if (bad_beats <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endfunction

    // Offers one sample beat, with a random number of idle cycles in front of it
    // when the sender is idling. Valid stays high into the next call, so back-to-back
    // beats keep valid asserted without a drop.
    task automatic send_sample(input logic [SAMP_W-1:0] sp, input logic [SAMP_W-1:0] ms);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_setpoint <= sp;
        i_measured <= ms;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        pending_drive_q.push_back(advance_controller(sp, ms));
    endtask

    // Stops offering samples and waits until every pending drive beat has arrived,
    // then lets the pipeline settle. The guard keeps a lost beat from hanging here;
    // the leftover is flagged at the end of the run.
    task automatic drain_pipeline();
        int guard;
        guard = 0;
        i_valid <= 1'b0;
        while (pending_drive_q.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (PIPE_SLACK) @(posedge i_clk);
    endtask

    // Gains change only while the pipeline is empty.
    task automatic write_gain(input logic [IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
        drain_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PROP_GAIN: begin
                kp_word = val;
            end
            REG_INTEG_GAIN: begin
                ki_word = val;
            end
            REG_DERIV_GAIN: begin
                kd_word = val;
            end
            default: begin
                // Writes to an unused index leave every gain alone.
            end
        endcase
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                             input logic [GAIN_W-1:0] kd);
        write_gain(REG_PROP_GAIN, kp);
        write_gain(REG_INTEG_GAIN, ki);
        write_gain(REG_DERIV_GAIN, kd);
    endtask

    // With the reset gains (proportional 0.1, others zero) a zero error holds the
    // drive, a modest error moves it a little, and full-scale errors of either sign
    // pin it at the top and the bottom of its range.
    task automatic test_reset_gains();
        send_sample(16'd0, 16'd0);
        send_sample(16'd100, 16'd50);
        send_sample(16'hFFFF, 16'h0000);
        send_sample(16'h0000, 16'hFFFF);
    endtask

    // All gains at full scale with extreme and alternating-bit samples, then all
    // gains at zero, where the drive must hold whatever value it had.
    task automatic test_gain_extremes();
        set_gains(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_sample(16'hFFFF, 16'h0000);
        send_sample(16'h0000, 16'hFFFF);
        send_sample(16'hAAAA, 16'h5555);
        send_sample(16'h5555, 16'hAAAA);
        set_gains(16'h0000, 16'h0000, 16'h0000);
        send_sample(16'd1234, 16'd4321);
    endtask

    // A write to the index past the last register must not disturb any gain.
    task automatic test_unused_index();
        set_gains(16'd1000, 16'd0, 16'd0);
        write_gain(REG_UNUSED, 16'hFFFF);
        send_sample(16'd300, 16'd100);
        send_sample(16'd300, 16'd300);
    endtask

    // Derivative only: a step in the error kicks the drive once, a steady error
    // leaves it, and the step back kicks it down again.
    task automatic test_derivative_kick();
        set_gains(16'd0, 16'd0, 16'd10);
        send_sample(16'd1000, 16'd0);
        send_sample(16'd1000, 16'd0);
        send_sample(16'd0, 16'd0);
    endtask

    // Integral only: the increment itself grows while the error persists, then
    // shrinks again when the error turns around.
    task automatic test_integral_ramp();
        set_gains(16'd0, 16'd100, 16'd0);
        repeat (3) send_sample(16'd100, 16'd0);
        repeat (3) send_sample(16'd0, 16'd100);
    endtask

    // Random traffic in blocks of thirty beats, each block under fresh gains. Most
    // gain sets are small so the drive spends its time inside the range rather than
    // on a rail; some are fully random and some sit on the extremes. Most samples
    // carry a small error whose sign mostly pushes the drive back toward mid range,
    // and the rest are fully random setpoint and measurement words.
    task automatic test_random_traffic(input int n_items, input int tx_idle,
                                       input int rx_idle);
        logic [SAMP_W-1:0] sp;
        logic [SAMP_W-1:0] ms;
        int                mag;
        int                roll;
        bit                push_down;
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        for (int n = 0; n < n_items; n++) begin
            if (n % 30 == 0) begin
                roll = $urandom_range(9);
                if (roll < 7) begin
                    set_gains(GAIN_W'($urandom_range(400)), GAIN_W'($urandom_range(20)),
                              GAIN_W'($urandom_range(60)));
                end else if (roll < 9) begin
                    set_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom));
                end else begin
                    set_gains($urandom_range(1) ? 16'hFFFF : 16'h0000,
                              $urandom_range(1) ? 16'hFFFF : 16'h0000,
                              $urandom_range(1) ? 16'hFFFF : 16'h0000);
                end
            end
            roll = $urandom_range(99);
            sp   = SAMP_W'($urandom);
            if (roll < 15) begin
                ms = SAMP_W'($urandom);
            end else begin
                mag = (roll < 35) ? $urandom_range(5000) : $urandom_range(300);
                push_down = (longint'(out_level) + longint'(integ_level) > OUT_MID);
                if ($urandom_range(9) < 3) begin
                    push_down = !push_down;
                end
                if (push_down) begin
                    ms = (int'(sp) + mag > 65535) ? 16'hFFFF : SAMP_W'(int'(sp) + mag);
                end else begin
                    ms = (int'(sp) < mag) ? 16'h0000 : SAMP_W'(int'(sp) - mag);
                end
            end
            send_sample(sp, ms);
        end
    endtask

    // Every drive beat is checked against the oldest pending value. Ready is
    // redrawn every cycle, so receiver stalls land on every phase of the pipeline.
    always @(posedge i_clk) begin : drive_check
        logic [DRIVE_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_drive_q.size() == 0) begin
                note_failure($sformatf("drive beat %0d arrived with nothing pending", o_drive));
            end else begin
                want = pending_drive_q.pop_front();
                if (o_drive !== want) begin
                    note_failure($sformatf("drive expected %0d, got %0d", want, o_drive));
                end
            end
        end
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        bad_beats     = 0;
        send_idle_pct = 33;
        recv_idle_pct = 63;
        kp_word       = PROP_GAIN_RST;
        ki_word       = INTEG_GAIN_RST;
        kd_word       = DERIV_GAIN_RST;
        integ_level   = '0;
        last_err      = '0;
        out_level     = '0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_PROP_GAIN;
        i_cfg_data    <= '0;
        i_valid       <= 1'b0;
        i_setpoint    <= '0;
        i_measured    <= '0;
        i_ready       <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_gains();
        test_gain_extremes();
        test_unused_index();
        test_derivative_kick();
        test_integral_ramp();

        // Sender sparse and receiver stalling, then the reverse, then full rate.
        test_random_traffic(150, 33, 63);
        test_random_traffic(150, 63, 33);
        test_random_traffic(150, 0, 0);

        drain_pipeline();
        if (pending_drive_q.size() != 0) begin
            note_failure($sformatf("%0d drive beats never arrived", pending_drive_q.size()));
        end
        if (bad_beats == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Watchdog: a time limit far beyond the slowest correct run.
    initial begin
        #8000000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ pid_clamped_drive.f @@
design/pcd_pkg.sv
design/pid_clamped_drive.sv
tb/pid_clamped_drive_test.sv
